// File: hw/rtl/hpos_pkg.sv
// Shared types, constants and helpers for the heap page occupancy statistics block.
// Depends on nothing; the top level takes every item by scoped name.
package hpos_pkg;

  // Register map of the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_PAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOC_PAGES = 2'd1;

  // Slot geometry and per-page counts
  localparam int unsigned SPP_W = 10;
  localparam logic [SPP_W-1:0] SPP_RESET = 10'd409;
  localparam int unsigned PAGE_W = 10;
  localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

  // Counter defaults
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned FILL_BINS = 6;
  localparam int unsigned ALLOC_W = 32;

  // Result channel
  localparam int unsigned STAT_IDX_W = 5;
  localparam int unsigned STAT_VAL_W = 32;
  localparam int unsigned NUM_STATS = 20;
  localparam logic [STAT_IDX_W-1:0] STAT_FRAG = 5'd0;
  localparam logic [STAT_IDX_W-1:0] STAT_ALLOC = 5'd1;
  localparam logic [STAT_IDX_W-1:0] STAT_FIRST_MEM = 5'd2;
  localparam logic [STAT_IDX_W-1:0] STAT_LAST = 5'(NUM_STATS - 1);

  // Counter memory layout: entry = statistic index minus two
  localparam int unsigned NUM_ENT = NUM_STATS - 2;
  localparam int unsigned ENT_W = $clog2(NUM_ENT);
  localparam logic [ENT_W-1:0] ENT_SEEN = 5'd0;
  localparam logic [ENT_W-1:0] ENT_LIVE = 5'd1;
  localparam logic [ENT_W-1:0] ENT_DEAD = 5'd2;
  localparam logic [ENT_W-1:0] ENT_UNPROT = 5'd3;
  localparam logic [ENT_W-1:0] ENT_UNCOL = 5'd4;
  localparam logic [ENT_W-1:0] ENT_REMSET = 5'd5;
  localparam logic [ENT_W-1:0] ENT_FRAGUNPROT = 5'd6;
  localparam logic [ENT_W-1:0] ENT_FREE = 5'd7;
  localparam logic [ENT_W-1:0] ENT_FULL = 5'd8;
  localparam logic [ENT_W-1:0] ENT_OBJ_LIVE = 5'd9;
  localparam logic [ENT_W-1:0] ENT_OBJ_DEAD = 5'd10;
  localparam logic [ENT_W-1:0] ENT_OBJ_UNPROT = 5'd11;
  localparam logic [ENT_W-1:0] ENT_BIN0 = 5'd12;
  localparam logic [ENT_W-1:0] ENT_LAST = 5'(NUM_ENT - 1);

  // Pending deltas: one sweep lap of page closes at most
  localparam int unsigned PEND_W = $clog2(NUM_ENT * (2 ** PAGE_W - 1) + 1);

  // Fixed-point reciprocal of 100, exact for products below 2^17
  localparam int unsigned PROD_W = 17;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [PROD_W+RECIP_SHIFT-7:0] RECIP_100 = 35'd167773;
  localparam logic [SPP_W-1:0] PERMILLE_EDGE = 10'd1000;

  typedef struct packed {
    logic [SPP_W-1:0] l1;  // 50%
    logic [SPP_W-1:0] l2;  // 95%
    logic [SPP_W-1:0] l3;  // 99%
    logic [SPP_W-1:0] l4;  // 99.9%
    logic [SPP_W-1:0] l5;  // full capacity
  } thr_t;

  function automatic logic [SPP_W-1:0] pct_of(input logic [SPP_W-1:0] spp,
                                               input logic [6:0] pct);
    logic [PROD_W-1:0] y;
    logic [PROD_W+RECIP_SHIFT-7:0] p;
    y = PROD_W'(spp) * PROD_W'(pct);
    p = (PROD_W + RECIP_SHIFT - 6)'(y) * RECIP_100;
    return SPP_W'(p >> RECIP_SHIFT);
  endfunction

  // spp*999/1000 = spp - ceil(spp/1000)
  function automatic thr_t calc_thr(input logic [SPP_W-1:0] spp);
    thr_t t;
    t.l1 = spp >> 1;
    t.l2 = pct_of(spp, 7'd95);
    t.l3 = pct_of(spp, 7'd99);
    if (spp == '0) begin
      t.l4 = '0;
    end else if (spp <= PERMILLE_EDGE) begin
      t.l4 = spp - SPP_W'(1);
    end else begin
      t.l4 = spp - SPP_W'(2);
    end
    t.l5 = spp;
    return t;
  endfunction

endpackage

// File: hw/rtl/heap_page_occupancy_stats.sv
// Heap page occupancy statistics: top level, counters held in one synchronous memory.
// Depends on hpos_pkg (constants, threshold helper).
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in       | in        | in_valid_i/in_ready_o   | kind_i, slot flags, page flags
//  out      | out       | out_valid_o/out_ready_i | stat_index_o, stat_value_o, last_stat_o
//
// Slot items: one per cycle while in_ready_o is high (not while clearing or reporting), no
// result. Page-close increments land in small pending registers; while it runs, a sweep
// walks the 18-entry counter memory one entry a cycle (read, then saturating add and
// write back the next cycle), so every entry is refreshed once per lap. Report item:
// drain the pending deltas, form the fragmented figure, then load each statistic while
// the output is free. Reset: a clearing pass zeroes the memory, taking no input item.
// The output register lets the block go back to taking slots while the last item waits.
module heap_page_occupancy_stats #(
  parameter int unsigned COUNT_WIDTH = hpos_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hpos_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hpos_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic                                slot_live_i,
  input  logic                                slot_unprotected_i,
  input  logic                                last_in_page_i,
  input  logic                                page_remembered_i,
  input  logic                                page_uncollectible_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hpos_pkg::STAT_IDX_W-1:0]     stat_index_o,
  output logic [hpos_pkg::STAT_VAL_W-1:0]     stat_value_o,
  output logic                                last_stat_o
);

  localparam int unsigned NE = hpos_pkg::NUM_ENT;
  localparam int unsigned EW = hpos_pkg::ENT_W;
  localparam int unsigned PW = hpos_pkg::PAGE_W;
  localparam int unsigned DW = hpos_pkg::PEND_W;
  localparam int unsigned SUB_W = COUNT_WIDTH + 1;
  localparam int unsigned CMP_W = (SUB_W > hpos_pkg::ALLOC_W) ? SUB_W
                                                             : hpos_pkg::ALLOC_W + 1;
  localparam logic [63:0] OUT_MAX = 64'(32'hFFFF_FFFF);

  typedef enum logic [3:0] {
    ST_CLEAR,     // zero the counter memory after reset
    ST_RUN,       // take slot items, sweep runs
    ST_FLUSH,     // drain pending deltas into memory
    ST_PRE_FREE,  // read free pages
    ST_PRE_FULL,  // read full pages
    ST_PRE_SUM,   // free + full
    ST_PRE_FRAG,  // allocated minus that, clamped
    ST_RD,        // read and clear one counter
    ST_LD         // load the output register
  } state_e;

  state_e state_q;

  // ---------------------------------------------------------------------------
  // Configuration: thresholds are formed at write time
  // ---------------------------------------------------------------------------
  hpos_pkg::thr_t                  thr_q;
  logic [hpos_pkg::ALLOC_W-1:0]    alloc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= hpos_pkg::calc_thr(hpos_pkg::SPP_RESET);
      alloc_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hpos_pkg::REG_SLOTS_PER_PAGE: thr_q <= hpos_pkg::calc_thr(
                                         cfg_data_i[hpos_pkg::SPP_W-1:0]);
        hpos_pkg::REG_ALLOC_PAGES:    alloc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Per-page counts and page-close increments
  // ---------------------------------------------------------------------------
  logic          in_acc;
  logic          slot_acc;
  logic          close_pg;
  logic [PW-1:0] live_q, dead_q, unp_q;
  logic [PW-1:0] live_n, dead_n, unp_n;
  logic [PW-1:0] inc [NE];

  assign in_ready_o = (state_q == ST_RUN);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_acc   = in_acc && !kind_i;
  assign close_pg   = slot_acc && last_in_page_i;

  always_comb begin
    live_n = live_q;
    dead_n = dead_q;
    unp_n  = unp_q;
    if (slot_live_i) begin
      if (live_q != hpos_pkg::PAGE_MAX) live_n = live_q + PW'(1);
    end else begin
      if (dead_q != hpos_pkg::PAGE_MAX) dead_n = dead_q + PW'(1);
    end
    if (slot_unprotected_i && unp_q != hpos_pkg::PAGE_MAX) unp_n = unp_q + PW'(1);
  end

  always_comb begin
    for (int e = 0; e < NE; e++) inc[e] = '0;
    if (close_pg) begin
      inc[hpos_pkg::ENT_SEEN]       = PW'(1);
      inc[hpos_pkg::ENT_LIVE]       = PW'(live_n != '0);
      inc[hpos_pkg::ENT_FREE]       = PW'(live_n == '0);
      inc[hpos_pkg::ENT_DEAD]       = PW'(dead_n != '0);
      inc[hpos_pkg::ENT_FULL]       = PW'(dead_n == '0);
      inc[hpos_pkg::ENT_UNPROT]     = PW'(unp_n != '0);
      inc[hpos_pkg::ENT_FRAGUNPROT] = PW'(unp_n != '0 && live_n != '0 && dead_n != '0);
      inc[hpos_pkg::ENT_REMSET]     = PW'(page_remembered_i);
      inc[hpos_pkg::ENT_UNCOL]      = PW'(page_uncollectible_i);
      inc[hpos_pkg::ENT_OBJ_LIVE]   = live_n;
      inc[hpos_pkg::ENT_OBJ_DEAD]   = dead_n;
      inc[hpos_pkg::ENT_OBJ_UNPROT] = unp_n;
      // cumulative fill bins; the last one counts every page
      inc[hpos_pkg::ENT_BIN0]        = PW'(live_n == '0);
      inc[hpos_pkg::ENT_BIN0 + EW'(1)] = PW'(live_n < thr_q.l1);
      inc[hpos_pkg::ENT_BIN0 + EW'(2)] = PW'(live_n < thr_q.l2);
      inc[hpos_pkg::ENT_BIN0 + EW'(3)] = PW'(live_n < thr_q.l3);
      inc[hpos_pkg::ENT_BIN0 + EW'(4)] = PW'(live_n < thr_q.l4);
      inc[hpos_pkg::ENT_BIN0 + EW'(hpos_pkg::FILL_BINS - 1)] = PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      dead_q <= '0;
      unp_q  <= '0;
    end else if (in_acc) begin
      if (kind_i || last_in_page_i) begin
        // page closed or report: start over
        live_q <= '0;
        dead_q <= '0;
        unp_q  <= '0;
      end else begin
        live_q <= live_n;
        dead_q <= dead_n;
        unp_q  <= unp_n;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pending deltas and the memory sweep
  // ---------------------------------------------------------------------------
  logic [DW-1:0] pend_q [NE];
  logic          pend_nz;
  logic          sweep_rd;
  logic [EW-1:0] ptr_q;
  logic          wr_vld_q;
  logic [EW-1:0] wr_addr_q;
  logic [DW-1:0] snap_q;

  always_comb begin
    pend_nz = 1'b0;
    for (int e = 0; e < NE; e++) pend_nz = pend_nz | (pend_q[e] != '0);
  end

  // stop reading once drained so the last write lands before the report reads
  assign sweep_rd = (state_q == ST_RUN) || (state_q == ST_FLUSH && pend_nz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < NE; e++) pend_q[e] <= '0;
      ptr_q    <= '0;
      wr_vld_q <= 1'b0;
    end else begin
      for (int e = 0; e < NE; e++) begin
        if (sweep_rd && ptr_q == EW'(e)) begin
          pend_q[e] <= DW'(inc[e]);
        end else begin
          pend_q[e] <= pend_q[e] + DW'(inc[e]);
        end
      end
      wr_vld_q <= sweep_rd;
      if (sweep_rd || state_q == ST_CLEAR) begin
        ptr_q <= (ptr_q == hpos_pkg::ENT_LAST) ? '0 : ptr_q + EW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= ptr_q;
    snap_q    <= pend_q[ptr_q];
  end

  // ---------------------------------------------------------------------------
  // Counter memory: one read port, one write port, registered read data
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] mem [NE];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   mem_re, mem_we;
  logic [EW-1:0]          mem_raddr, mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [SUB_W-1:0]       sat_sum;
  logic [4:0]             idx_q;
  logic [EW-1:0]          idx_ent;

  assign idx_ent = EW'(idx_q - hpos_pkg::STAT_FIRST_MEM);
  assign sat_sum = {1'b0, rd_data_q} + SUB_W'(snap_q);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ptr_q;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = sat_sum[SUB_W-1] ? '1 : sat_sum[COUNT_WIDTH-1:0];
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = '0;
      end
      ST_PRE_FREE: begin
        mem_re    = 1'b1;
        mem_raddr = hpos_pkg::ENT_FREE;
      end
      ST_PRE_FULL: begin
        mem_re    = 1'b1;
        mem_raddr = hpos_pkg::ENT_FULL;
      end
      ST_RD: begin
        // read the counter and clear it in the same cycle
        mem_re    = 1'b1;
        mem_raddr = idx_ent;
        mem_we    = 1'b1;
        mem_waddr = idx_ent;
        mem_wdata = '0;
      end
      default: begin
        mem_re = sweep_rd;
        mem_we = wr_vld_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_data_q <= mem[mem_raddr];
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  // ---------------------------------------------------------------------------
  // Report sequencer and output register
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0]           free_q;
  logic [SUB_W-1:0]                 sub_q;
  logic [hpos_pkg::STAT_VAL_W-1:0]  frag_q;
  logic                             out_vld_q;
  logic [hpos_pkg::STAT_IDX_W-1:0]  out_idx_q;
  logic [hpos_pkg::STAT_VAL_W-1:0]  out_val_q;
  logic                             out_last_q;
  logic [63:0]                      mem_val64;
  logic [hpos_pkg::STAT_VAL_W-1:0]  mem_val32;
  logic [hpos_pkg::STAT_VAL_W-1:0]  ld_val;
  logic                             out_free;
  logic [CMP_W-1:0]                 alloc_ext, sub_ext, frag_ext;

  assign mem_val64 = 64'(rd_data_q);
  assign mem_val32 = (mem_val64 > OUT_MAX) ? '1 : mem_val64[hpos_pkg::STAT_VAL_W-1:0];
  assign alloc_ext = CMP_W'(alloc_q);
  assign sub_ext   = CMP_W'(sub_q);
  assign frag_ext  = alloc_ext - sub_ext;
  assign out_free  = !out_vld_q || out_ready_i;

  always_comb begin
    case (idx_q)
      hpos_pkg::STAT_FRAG:  ld_val = frag_q;
      hpos_pkg::STAT_ALLOC: ld_val = alloc_q;
      default:              ld_val = mem_val32;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (ptr_q == hpos_pkg::ENT_LAST) state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (in_acc && kind_i) state_q <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (!pend_nz && !wr_vld_q) state_q <= ST_PRE_FREE;
        end
        ST_PRE_FREE: state_q <= ST_PRE_FULL;
        ST_PRE_FULL: begin
          free_q  <= rd_data_q;
          state_q <= ST_PRE_SUM;
        end
        ST_PRE_SUM: begin
          sub_q   <= SUB_W'(free_q) + SUB_W'(rd_data_q);
          state_q <= ST_PRE_FRAG;
        end
        ST_PRE_FRAG: begin
          frag_q  <= (alloc_ext > sub_ext) ? frag_ext[hpos_pkg::STAT_VAL_W-1:0] : '0;
          idx_q   <= hpos_pkg::STAT_FRAG;
          state_q <= ST_LD;
        end
        ST_RD: state_q <= ST_LD;
        ST_LD: begin
          // hold until the output register frees up
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_idx_q  <= idx_q;
            out_val_q  <= ld_val;
            out_last_q <= (idx_q == hpos_pkg::STAT_LAST);
            if (idx_q == hpos_pkg::STAT_LAST) begin
              state_q <= ST_RUN;
            end else begin
              idx_q   <= idx_q + 5'd1;
              state_q <= (idx_q + 5'd1 >= hpos_pkg::STAT_FIRST_MEM) ? ST_RD : ST_LD;
            end
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  assign out_valid_o  = out_vld_q;
  assign stat_index_o = out_idx_q;
  assign stat_value_o = out_val_q;
  assign last_stat_o  = out_last_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for heap_page_occupancy_stats: streams heap slots and report
// requests, predicts every statistic of a report and checks the results in order.
// Depends on hpos_pkg and the heap_page_occupancy_stats RTL.
module tb;

  localparam int unsigned GAP_MAX = 10;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned LONG_PAGE = 1030;
  localparam int unsigned VAL_W = hpos_pkg::STAT_VAL_W;
  localparam int unsigned IDX_W = hpos_pkg::STAT_IDX_W;
  localparam int unsigned SPP_W = hpos_pkg::SPP_W;

  // indexes past the register map; writes to them must be dropped
  localparam logic [hpos_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [hpos_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // positions of the statistics in a report
  localparam int ST_SEEN = 2, ST_WITH_LIVE = 3, ST_WITH_DEAD = 4, ST_WITH_UNPROT = 5,
                 ST_UNCOL = 6, ST_REMSET = 7, ST_FRAGUNPROT = 8, ST_FREE = 9, ST_FULL = 10,
                 ST_OBJ_LIVE = 11, ST_OBJ_DEAD = 12, ST_OBJ_UNPROT = 13, ST_BIN0 = 14;

  typedef enum logic {KIND_SLOT, KIND_REPORT} kind_e;
  typedef enum int {UNP_NONE, UNP_ALL, UNP_MIXED} unprot_mode_e;
  typedef enum int {
    PG_SEEN, PG_LIVE, PG_DEAD, PG_UNPROT, PG_FREE, PG_FULL, PG_FRAGUNPROT, PG_REMSET,
    PG_UNCOL, PG_COUNT
  } page_ctr_e;
  typedef enum int {OBJ_LIVE, OBJ_DEAD, OBJ_UNPROT, OBJ_COUNT} obj_total_e;

  typedef struct packed {
    kind_e kind;
    logic  live;
    logic  unprot;
    logic  last;
    logic  remembered;
    logic  uncollectible;
  } slot_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             last;
  } stat_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [hpos_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [hpos_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  slot_item_t in_item = '0;
  logic kind_i, slot_live_i, slot_unprotected_i, last_in_page_i;
  logic page_remembered_i, page_uncollectible_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IDX_W-1:0] stat_index_o;
  logic [VAL_W-1:0] stat_value_o;
  logic last_stat_o;

  assign kind_i               = in_item.kind;
  assign slot_live_i          = in_item.live;
  assign slot_unprotected_i   = in_item.unprot;
  assign last_in_page_i       = in_item.last;
  assign page_remembered_i    = in_item.remembered;
  assign page_uncollectible_i = in_item.uncollectible;

  heap_page_occupancy_stats DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .kind_i               (kind_i),
    .slot_live_i          (slot_live_i),
    .slot_unprotected_i   (slot_unprotected_i),
    .last_in_page_i       (last_in_page_i),
    .page_remembered_i    (page_remembered_i),
    .page_uncollectible_i (page_uncollectible_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .stat_index_o         (stat_index_o),
    .stat_value_o         (stat_value_o),
    .last_stat_o          (last_stat_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Occupancy predictor: its own copy of the registers and all counts
  // ---------------------------------------------------------------------------
  logic [SPP_W-1:0] spp_cfg = hpos_pkg::SPP_RESET;
  logic [VAL_W-1:0] alloc_cfg = '0;
  logic [hpos_pkg::PAGE_W-1:0] live_run, dead_run, unprot_run;
  logic [VAL_W-1:0] page_ctr [PG_COUNT];
  logic [VAL_W-1:0] obj_total [OBJ_COUNT];
  logic [VAL_W-1:0] fill_bin [hpos_pkg::FILL_BINS];

  stat_t expected_stats[$];     // statistics still owed by the block, oldest first
  slot_item_t slot_queue[$];    // items waiting for the driver
  int mismatches = 0;

  function automatic logic [VAL_W-1:0] bump(input logic [VAL_W-1:0] c,
                                            input logic [VAL_W-1:0] v);
    logic [VAL_W:0] s;
    s = {1'b0, c} + {1'b0, v};
    return s[VAL_W] ? '1 : s[VAL_W-1:0];
  endfunction

  function automatic logic [hpos_pkg::PAGE_W-1:0] run_inc(
      input logic [hpos_pkg::PAGE_W-1:0] c);
    return (c == hpos_pkg::PAGE_MAX) ? c : c + 1'b1;
  endfunction

  // bin k counts pages whose live count lies below this limit
  function automatic int unsigned fill_limit(input logic [SPP_W-1:0] spp, input int k);
    int unsigned s;
    s = spp;
    case (k)
      0:       return 1;
      1:       return s * 50 / 100;
      2:       return s * 95 / 100;
      3:       return s * 99 / 100;
      4:       return s * 999 / 1000;
      default: return s;
    endcase
  endfunction

  task automatic clear_tallies();
    live_run = '0;
    dead_run = '0;
    unprot_run = '0;
    for (int i = 0; i < PG_COUNT; i++) page_ctr[i] = '0;
    for (int i = 0; i < OBJ_COUNT; i++) obj_total[i] = '0;
    for (int i = 0; i < hpos_pkg::FILL_BINS; i++) fill_bin[i] = '0;
  endtask

  task automatic retire_page(input logic remembered, input logic uncollectible);
    if (remembered) page_ctr[PG_REMSET] = bump(page_ctr[PG_REMSET], 1);
    if (uncollectible) page_ctr[PG_UNCOL] = bump(page_ctr[PG_UNCOL], 1);
    page_ctr[PG_SEEN] = bump(page_ctr[PG_SEEN], 1);
    obj_total[OBJ_LIVE] = bump(obj_total[OBJ_LIVE], VAL_W'(live_run));
    obj_total[OBJ_DEAD] = bump(obj_total[OBJ_DEAD], VAL_W'(dead_run));
    if (live_run != 0) page_ctr[PG_LIVE] = bump(page_ctr[PG_LIVE], 1);
    else page_ctr[PG_FREE] = bump(page_ctr[PG_FREE], 1);
    if (dead_run != 0) page_ctr[PG_DEAD] = bump(page_ctr[PG_DEAD], 1);
    else page_ctr[PG_FULL] = bump(page_ctr[PG_FULL], 1);
    if (unprot_run != 0) begin
      page_ctr[PG_UNPROT] = bump(page_ctr[PG_UNPROT], 1);
      obj_total[OBJ_UNPROT] = bump(obj_total[OBJ_UNPROT], VAL_W'(unprot_run));
      if (live_run != 0 && dead_run != 0)
        page_ctr[PG_FRAGUNPROT] = bump(page_ctr[PG_FRAGUNPROT], 1);
    end
    // bins are cumulative; the top bin also takes pages at or above capacity
    for (int i = 0; i < hpos_pkg::FILL_BINS; i++)
      if (live_run < fill_limit(spp_cfg, i)) fill_bin[i] = bump(fill_bin[i], 1);
    if (live_run >= fill_limit(spp_cfg, hpos_pkg::FILL_BINS - 1))
      fill_bin[hpos_pkg::FILL_BINS-1] = bump(fill_bin[hpos_pkg::FILL_BINS-1], 1);
    live_run = '0;
    dead_run = '0;
    unprot_run = '0;
  endtask

  task automatic emit_report();
    logic [VAL_W-1:0] stat [hpos_pkg::NUM_STATS];
    logic [VAL_W+1:0] retired;
    stat_t s;
    // fragmented = allocated - full - free, held at zero
    retired = page_ctr[PG_FULL] + page_ctr[PG_FREE];
    stat[hpos_pkg::STAT_FRAG] = ({2'b00, alloc_cfg} > retired) ?
                                alloc_cfg - retired[VAL_W-1:0] : '0;
    stat[hpos_pkg::STAT_ALLOC] = alloc_cfg;
    stat[ST_SEEN]        = page_ctr[PG_SEEN];
    stat[ST_WITH_LIVE]   = page_ctr[PG_LIVE];
    stat[ST_WITH_DEAD]   = page_ctr[PG_DEAD];
    stat[ST_WITH_UNPROT] = page_ctr[PG_UNPROT];
    stat[ST_UNCOL]       = page_ctr[PG_UNCOL];
    stat[ST_REMSET]      = page_ctr[PG_REMSET];
    stat[ST_FRAGUNPROT]  = page_ctr[PG_FRAGUNPROT];
    stat[ST_FREE]        = page_ctr[PG_FREE];
    stat[ST_FULL]        = page_ctr[PG_FULL];
    stat[ST_OBJ_LIVE]    = obj_total[OBJ_LIVE];
    stat[ST_OBJ_DEAD]    = obj_total[OBJ_DEAD];
    stat[ST_OBJ_UNPROT]  = obj_total[OBJ_UNPROT];
    for (int i = 0; i < hpos_pkg::FILL_BINS; i++) stat[ST_BIN0 + i] = fill_bin[i];
    for (int i = 0; i < hpos_pkg::NUM_STATS; i++) begin
      s.index = IDX_W'(i);
      s.value = stat[i];
      s.last  = (IDX_W'(i) == hpos_pkg::STAT_LAST);
      expected_stats.push_back(s);
    end
    // a report also drops a partly counted page
    clear_tallies();
  endtask

  task automatic take_item(input slot_item_t it);
    if (it.kind == KIND_REPORT) begin
      emit_report();
    end else begin
      if (it.live) live_run = run_inc(live_run);
      else dead_run = run_inc(dead_run);
      if (it.unprot) unprot_run = run_inc(unprot_run);
      if (it.last) retire_page(it.remembered, it.uncollectible);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge, predict and compare
  // ---------------------------------------------------------------------------
  int unsigned in_taken_cnt = 0;
  int unsigned out_taken_cnt = 0;

  always @(posedge clk_i) begin : watch
    stat_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        take_item(in_item);
        in_taken_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        out_taken_cnt++;
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result index %0d value %0d", $time, stat_index_o,
                   stat_value_o);
          mismatches++;
        end else begin
          want = expected_stats.pop_front();
          if (stat_index_o !== want.index) begin
            $display("%0t: stat_index expected %0d actual %0d", $time, want.index,
                     stat_index_o);
            mismatches++;
          end
          if (stat_value_o !== want.value) begin
            $display("%0t: stat %0d value expected %0d actual %0d", $time, want.index,
                     want.value, stat_value_o);
            mismatches++;
          end
          if (last_stat_o !== want.last) begin
            $display("%0t: stat %0d last_stat expected %0b actual %0b", $time, want.index,
                     want.last, last_stat_o);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: present queued items at the falling edge, hold until taken, then
  // idle a drawn number of cycles; calm stretches draw no idling at all
  // ---------------------------------------------------------------------------
  int unsigned in_sent_cnt = 0;
  int unsigned in_wait = 0;
  bit in_calm = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken_cnt == in_sent_cnt)) begin
      if (in_wait > 0) begin
        in_valid_i <= 1'b0;
        in_wait--;
      end else if (slot_queue.size() > 0) begin
        in_item <= slot_queue.pop_front();
        in_valid_i <= 1'b1;
        in_sent_cnt++;
        if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
        in_wait = in_calm ? 0 : $urandom_range(0, GAP_MAX);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: after each result, stall a drawn number of cycles
  int unsigned out_seen_cnt = 0;
  int unsigned out_stall = 0;
  bit out_calm = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken_cnt != out_seen_cnt) begin
        out_seen_cnt = out_taken_cnt;
        if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (out_stall > 0) begin
        out_ready_i <= 1'b0;
        out_stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_slot(input logic live, input logic unprot, input logic last,
                            input logic remembered, input logic uncollectible);
    slot_item_t it;
    it.kind = KIND_SLOT;
    it.live = live;
    it.unprot = unprot;
    it.last = last;
    it.remembered = remembered;
    it.uncollectible = uncollectible;
    slot_queue.push_back(it);
  endtask

  // report with random junk in the fields it ignores
  task automatic queue_report();
    slot_item_t it;
    {it.live, it.unprot, it.last, it.remembered, it.uncollectible} = 5'($urandom);
    it.kind = KIND_REPORT;
    slot_queue.push_back(it);
  endtask

  task automatic queue_noise();
    slot_item_t it;
    {it.live, it.unprot, it.last, it.remembered, it.uncollectible} = 5'($urandom);
    it.kind = KIND_SLOT;
    slot_queue.push_back(it);
  endtask

  // one well-formed page with live and dead slots shuffled, closed by its last slot
  task automatic queue_page(input int unsigned live_n, input int unsigned dead_n,
                            input unprot_mode_e mode);
    int unsigned rem_live;
    int unsigned rem_all;
    logic live;
    logic unprot;
    rem_live = live_n;
    rem_all = live_n + dead_n;
    while (rem_all > 0) begin
      live = ($urandom_range(1, rem_all) <= rem_live);
      unprot = (mode == UNP_ALL) || (mode == UNP_MIXED && $urandom_range(0, 1) == 1);
      queue_slot(live, unprot, rem_all == 1, $urandom_range(0, 1), $urandom_range(0, 1));
      if (live) rem_live--;
      rem_all--;
    end
  endtask

  // hold until the block has drained and every expected statistic has come
  task automatic settle();
    while (slot_queue.size() != 0 || in_valid_i || expected_stats.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [hpos_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hpos_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hpos_pkg::REG_SLOTS_PER_PAGE: spp_cfg = data[SPP_W-1:0];
      hpos_pkg::REG_ALLOC_PAGES:    alloc_cfg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Reconfigure while idle, then mostly well-formed pages whose live counts sit
  // on the fill thresholds, with stray slots and early reports mixed in.
  task automatic run_phase(input logic [SPP_W-1:0] spp, input logic [VAL_W-1:0] alloc,
                           input int unsigned budget, input int unsigned cap,
                           input bit long_pages);
    int unsigned used;
    int unsigned pick;
    int unsigned live_n;
    int unsigned dead_n;
    settle();
    write_reg(hpos_pkg::REG_ALLOC_PAGES, alloc);
    write_reg(hpos_pkg::REG_SLOTS_PER_PAGE, {22'($urandom), spp});
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        queue_report();
        used++;
      end else if (pick < 3) begin
        queue_noise();
        used++;
      end else begin
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          live_n = 0;
        end else if (pick <= 5) begin
          // one below, on, or one above the threshold
          live_n = fill_limit(spp, pick) + $urandom_range(0, 2);
          live_n = (live_n > 0) ? live_n - 1 : 0;
        end else if (pick == 6) begin
          live_n = $urandom_range(0, spp);
        end else begin
          live_n = spp + $urandom_range(1, 2);
        end
        if (live_n > cap) live_n = cap;
        dead_n = $urandom_range(0, 3);
        if (live_n + dead_n == 0) dead_n = 1;
        queue_page(live_n, dead_n, unprot_mode_e'($urandom_range(0, 2)));
        used += live_n + dead_n;
      end
    end
    if (long_pages) begin
      // drive the per-page counts into saturation
      queue_page(LONG_PAGE, 0, UNP_ALL);
      queue_page(0, LONG_PAGE, UNP_MIXED);
    end
    queue_report();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_tallies();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset settings: report on empty counts, then pages of each shape
    queue_report();
    queue_slot(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_slot(1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    queue_slot(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);   // live, dead and unprotected page
    queue_slot(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);   // free page
    queue_slot(1'b1, 1'b0, 1'b1, 1'b0, 1'b1);   // full page
    queue_slot(1'b0, 1'b1, 1'b1, 1'b1, 1'b0);   // free page, unprotected
    queue_slot(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_slot(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_report();                               // drops the partial page
    queue_slot(1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_report();

    // Directed, one slot per page and every page allocated
    settle();
    write_reg(hpos_pkg::REG_SLOTS_PER_PAGE, {22'h3F_FFFF, 10'd1});
    write_reg(hpos_pkg::REG_ALLOC_PAGES, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h0000_0000);
    queue_slot(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_slot(1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_slot(1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    queue_slot(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);   // overfull page
    queue_report();

    // Random phases; zero capacity and full capacity among them
    run_phase(10'd2, 32'd0, 35, 64, 1'b0);
    run_phase(10'd0, $urandom, 30, 64, 1'b0);
    run_phase(10'd1023, 32'hFFFF_FFFF, 25, 12, 1'b1);
    run_phase(10'd7, 32'd3, 35, 64, 1'b0);
    run_phase(10'd20, $urandom_range(0, 60), 40, 64, 1'b0);
    run_phase(10'd1, 32'hFFFF_FFFF, 30, 64, 1'b0);
    for (int k = 0; k < 4; k++)
      run_phase(SPP_W'($urandom_range(3, 40)), $urandom_range(0, 100), 35, 64, 1'b0);
    run_phase(hpos_pkg::SPP_RESET, $urandom, 30, 40, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("[heap_page_occupancy_stats] OK");
    end else begin
      $display("[heap_page_occupancy_stats] ERROR");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends here
  initial begin
    #5_000_000;
    $display("[heap_page_occupancy_stats] ERROR");
    $finish;
  end

endmodule
